// File: rtl/core/ewsn_pkg.sv
// shared types and constants of the echo wave sum node
package ewsn_pkg;

    localparam int MAX_NEIGHBOURS = 8;
    localparam int SUM_WIDTH      = 32;
    localparam int IDX_W          = 3;
    localparam int CNT_W          = 4;
    localparam int STORE_W        = 31;
    localparam int MODE_W         = 2;
    localparam int KIND_W         = 2;

    typedef logic [MODE_W-1:0]    mode_t;
    typedef logic [KIND_W-1:0]    kind_t;
    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [SUM_WIDTH-1:0] sum_t;

    localparam mode_t MODE_START = 2'd0;
    localparam mode_t MODE_INFO  = 2'd1;
    localparam mode_t MODE_ECHO  = 2'd2;
    localparam mode_t MODE_UNK   = 2'd3;

    localparam kind_t KIND_INFO   = 2'd0;
    localparam kind_t KIND_ECHO   = 2'd1;
    localparam kind_t KIND_RESULT = 2'd2;
    localparam kind_t KIND_ERROR  = 2'd3;

    localparam logic CFG_NEIGHBOURS = 1'b0;
    localparam logic CFG_STORAGE    = 1'b1;

    // what one accepted beat asks the sequencer to send
    typedef struct packed {
        logic flood;
        logic skip_valid;
        idx_t skip_idx;
        logic fin;
    } plan_t;

    typedef struct packed {
        plan_t plan;
        cnt_t  n_eff;
        logic  out_free;
    } status_t;

    typedef struct packed {
        logic accept;
        logic emit_info;
        logic emit_final;
        idx_t idx;
        logic last;
    } cmd_t;

endpackage

// File: rtl/core/ewsn_ctrl.sv
// sequencer of the echo wave node: accepts a beat and walks its output beats
module ewsn_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  ewsn_pkg::status_t status,
    output ewsn_pkg::cmd_t    cmd
);
    import ewsn_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_FLOOD, S_FINAL} state_t;

    state_t state_reg, state_next;
    idx_t   idx_reg, idx_next;

    logic at_end;
    logic skip_now;
    logic near_end;

    always_comb
    begin
        at_end   = ({1'b0, idx_reg} == status.n_eff - 4'd1);
        skip_now = status.plan.skip_valid && (idx_reg == status.plan.skip_idx);
        // the only later index is the skipped sender
        near_end = ({1'b0, idx_reg} + 4'd2 == status.n_eff) && status.plan.skip_valid
                   && ({1'b0, status.plan.skip_idx} == status.n_eff - 4'd1);
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.idx        = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_FLOOD;
                    idx_next   = '0;
                end
            end
            S_FLOOD:
            begin
                if (!status.plan.flood)
                begin
                    state_next = status.plan.fin ? S_FINAL : S_IDLE;
                end
                else if (skip_now || status.out_free)
                begin
                    cmd.emit_info = !skip_now;
                    cmd.last      = !status.plan.fin && (at_end || near_end);
                    if (at_end)
                    begin
                        state_next = status.plan.fin ? S_FINAL : S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            S_FINAL:
            begin
                if (status.out_free)
                begin
                    cmd.emit_final = 1'b1;
                    cmd.last       = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

// File: rtl/core/ewsn_dp.sv
// datapath of the echo wave node: node state, saturating sum, output register
module ewsn_dp
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [ewsn_pkg::STORE_W-1:0]  cfg_data,
    input  ewsn_pkg::mode_t               mode,
    input  ewsn_pkg::idx_t                sender_index,
    input  ewsn_pkg::sum_t                echo_sum,
    input  ewsn_pkg::cmd_t                cmd,
    output ewsn_pkg::status_t             status,
    input  logic                          out_ready,
    output logic                          out_valid,
    output ewsn_pkg::kind_t               msg_kind,
    output ewsn_pkg::idx_t                dest_index,
    output ewsn_pkg::sum_t                value,
    output logic                          last
);
    import ewsn_pkg::*;

    localparam sum_t SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam sum_t SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};
    localparam sum_t MINUS_ONE = {SUM_WIDTH{1'b1}};

    // configuration
    cnt_t                nc_reg;
    logic [STORE_W-1:0]  own_reg;

    // node state
    logic informed_reg, informed_next;
    logic pknown_reg, pknown_next;
    idx_t parent_reg, parent_next;
    cnt_t count_reg, count_next;
    sum_t sum_reg, sum_next;

    // plan and final beat of the current item
    plan_t plan_reg, plan_next;
    kind_t fin_kind_reg, fin_kind_next;
    idx_t  fin_dest_reg, fin_dest_next;
    sum_t  fin_value_reg, fin_value_next;

    // output register
    logic  out_valid_reg;
    kind_t kind_reg;
    idx_t  dest_reg;
    sum_t  value_reg;
    logic  last_reg;

    cnt_t             n_eff;
    logic [SUM_WIDTH:0] wide_sum;
    sum_t             sat_sum;
    sum_t             own_sum;
    cnt_t             count_inc;
    logic             bad;
    logic             first;
    logic             pk;

    always_comb
    begin
        if (nc_reg == '0)
            n_eff = 4'd1;
        else if (nc_reg > 4'(MAX_NEIGHBOURS))
            n_eff = 4'(MAX_NEIGHBOURS);
        else
            n_eff = nc_reg;
    end

    always_comb
    begin
        wide_sum = {sum_reg[SUM_WIDTH-1], sum_reg} + {echo_sum[SUM_WIDTH-1], echo_sum};
        if (wide_sum[SUM_WIDTH] != wide_sum[SUM_WIDTH-1])
            sat_sum = wide_sum[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
        else
            sat_sum = wide_sum[SUM_WIDTH-1:0];
        own_sum   = {{(SUM_WIDTH-STORE_W){1'b0}}, own_reg};
        count_inc = count_reg + 4'd1;
        bad       = (mode == MODE_UNK) || ({1'b0, sender_index} >= n_eff);
        first     = !informed_reg;
        pk        = first || pknown_reg;
    end

    always_comb
    begin
        informed_next  = informed_reg;
        pknown_next    = pknown_reg;
        parent_next    = parent_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        plan_next      = plan_reg;
        fin_kind_next  = fin_kind_reg;
        fin_dest_next  = fin_dest_reg;
        fin_value_next = fin_value_reg;
        if (cmd.accept)
        begin
            plan_next      = '0;
            fin_kind_next  = KIND_ERROR;
            fin_dest_next  = '0;
            fin_value_next = MINUS_ONE;
            if (mode == MODE_START)
            begin
                informed_next   = 1'b1;
                plan_next.flood = 1'b1;
            end
            else if (bad)
            begin
                plan_next.fin = 1'b1;
            end
            else
            begin
                sum_next   = (mode == MODE_ECHO) ? sat_sum : sum_reg;
                count_next = count_inc;
                if (first)
                begin
                    informed_next        = 1'b1;
                    pknown_next          = 1'b1;
                    parent_next          = sender_index;
                    plan_next.flood      = 1'b1;
                    plan_next.skip_valid = 1'b1;
                    plan_next.skip_idx   = sender_index;
                end
                if (count_inc == n_eff)
                begin
                    plan_next.fin  = 1'b1;
                    fin_kind_next  = pk ? KIND_ECHO : KIND_RESULT;
                    fin_dest_next  = pk ? (first ? sender_index : parent_reg) : '0;
                    fin_value_next = sum_next;
                    // wave complete, back to idle
                    informed_next  = 1'b0;
                    pknown_next    = 1'b0;
                    count_next     = '0;
                    sum_next       = own_sum;
                end
            end
        end
        else if (cfg_we && (cfg_index == CFG_STORAGE) && !informed_reg && (count_reg == '0))
        begin
            sum_next = {{(SUM_WIDTH-STORE_W){1'b0}}, cfg_data};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nc_reg       <= 4'd1;
            own_reg      <= '0;
            informed_reg <= 1'b0;
            pknown_reg   <= 1'b0;
            parent_reg   <= '0;
            count_reg    <= '0;
            sum_reg      <= '0;
            plan_reg     <= '0;
        end
        else
        begin
            if (cfg_we && (cfg_index == CFG_NEIGHBOURS))
                nc_reg <= cfg_data[CNT_W-1:0];
            if (cfg_we && (cfg_index == CFG_STORAGE))
                own_reg <= cfg_data;
            informed_reg <= informed_next;
            pknown_reg   <= pknown_next;
            parent_reg   <= parent_next;
            count_reg    <= count_next;
            sum_reg      <= sum_next;
            plan_reg     <= plan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fin_kind_reg  <= fin_kind_next;
        fin_dest_reg  <= fin_dest_next;
        fin_value_reg <= fin_value_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit_info || cmd.emit_final)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_info)
        begin
            kind_reg  <= KIND_INFO;
            dest_reg  <= cmd.idx;
            value_reg <= MINUS_ONE;
            last_reg  <= cmd.last;
        end
        else if (cmd.emit_final)
        begin
            kind_reg  <= fin_kind_reg;
            dest_reg  <= fin_dest_reg;
            value_reg <= fin_value_reg;
            last_reg  <= cmd.last;
        end
    end

    always_comb
    begin
        status.plan     = plan_reg;
        status.n_eff    = n_eff;
        status.out_free = !out_valid_reg || out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign msg_kind   = kind_reg;
    assign dest_index = dest_reg;
    assign value      = value_reg;
    assign last       = last_reg;

endmodule

// File: rtl/core/echo_wave_sum_node.sv
// top level of the echo wave sum node
//
//  channel   dir  handshake             contents
//  s_*       in   s_tvalid / s_tready   received message
//  m_*       out  m_tvalid / m_tready   sent message, m_tlast on the final beat
//  cfg_*     in   cfg_we                register write, no read-back
//
// one message at a time: the message is accepted, then each neighbour index is walked
// when info is flooded (the sender's own index is walked without a beat) or
// an empty step is taken when nothing is flooded, then a closing echo,
// result or error is sent when one is due (neighbour count at most 8)
// m_tready low holds the output register and pauses the neighbour walk
// reset: neighbour count 1, storage 0, node idle
module echo_wave_sum_node
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [30:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // mode[1:0], sender_index[4:2], echo_sum[36:5], zeros
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // msg_kind[1:0], dest_index[4:2], value[36:5], zeros
    output logic        m_tlast
);
    import ewsn_pkg::*;

    status_t status;
    cmd_t    cmd;
    kind_t   msg_kind;
    idx_t    dest_index;
    sum_t    value;

    ewsn_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ewsn_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mode         (s_tdata[1:0]),
        .sender_index (s_tdata[4:2]),
        .echo_sum     (s_tdata[36:5]),
        .cmd          (cmd),
        .status       (status),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .msg_kind     (msg_kind),
        .dest_index   (dest_index),
        .value        (value),
        .last         (m_tlast)
    );

    assign m_tdata = {3'b000, value, dest_index, msg_kind};

endmodule

// File: test/tb.sv
// testbench for the echo wave sum node: directed waves, random waves and a checker
`timescale 1ns / 100ps

module tb;
    import ewsn_pkg::*;

    localparam int     STALL_LIMIT   = 2000;
    localparam int     SETTLE_CYCLES = 16;
    localparam int     HOLD_CYCLES   = 60;
    localparam int     PRINT_CAP     = 50;
    localparam longint SUM_HI        = 64'sd2147483647;
    localparam longint SUM_LO        = -SUM_HI - 1;

    typedef struct packed {
        kind_t kind;
        idx_t  dest;
        sum_t  value;
        logic  last;
    } sent_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [30:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // mode[1:0], sender_index[4:2], echo_sum[36:5], zeros
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // msg_kind[1:0], dest_index[4:2], value[36:5], zeros
    logic        m_tlast;

    // node state as the checker sees it
    logic        seen_info;
    logic        has_parent;
    idx_t        parent_nb;
    cnt_t        msg_count;
    sum_t        wave_sum;
    logic [3:0]  nb_count_reg;
    logic [30:0] storage_reg;

    sent_t       expected_sends[$];
    int          err_count;
    int          sent_items;
    int          stall_cycles;
    logic        no_gaps;
    logic        hold_req;

    echo_wave_sum_node DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic int eff_neighbours();
        if (nb_count_reg == 4'd0)
            return 1;
        if (nb_count_reg > MAX_NEIGHBOURS)
            return MAX_NEIGHBOURS;
        return int'(nb_count_reg);
    endfunction

    function automatic void node_to_idle();
        seen_info  = 1'b0;
        has_parent = 1'b0;
        msg_count  = '0;
        wave_sum   = {1'b0, storage_reg};
    endfunction

    // works out the messages sent in answer to one received message
    function automatic void predict_replies(mode_t mode, idx_t sender, sum_t esum);
        sent_t  outs[MAX_NEIGHBOURS + 2];
        int     k;
        int     n;
        longint acc;
        k = 0;
        n = eff_neighbours();
        if (mode == MODE_START)
        begin
            seen_info = 1'b1;
            for (int i = 0; i < n; i++)
            begin
                outs[k] = '{KIND_INFO, idx_t'(i), '1, 1'b0};
                k++;
            end
        end
        else if (mode == MODE_UNK || sender >= n)
        begin
            outs[k] = '{KIND_ERROR, '0, '1, 1'b0};
            k++;
        end
        else
        begin
            if (mode == MODE_ECHO)
            begin
                acc = longint'($signed(wave_sum)) + longint'($signed(esum));
                if (acc > SUM_HI)
                    acc = SUM_HI;
                else if (acc < SUM_LO)
                    acc = SUM_LO;
                wave_sum = sum_t'(acc);
            end
            msg_count = msg_count + 1'b1;
            if (!seen_info)
            begin
                seen_info  = 1'b1;
                has_parent = 1'b1;
                parent_nb  = sender;
                for (int i = 0; i < n; i++)
                begin
                    if (i != sender)
                    begin
                        outs[k] = '{KIND_INFO, idx_t'(i), '1, 1'b0};
                        k++;
                    end
                end
            end
            if (msg_count == n)
            begin
                if (has_parent)
                    outs[k] = '{KIND_ECHO, parent_nb, wave_sum, 1'b0};
                else
                    outs[k] = '{KIND_RESULT, '0, wave_sum, 1'b0};
                k++;
                node_to_idle();
            end
        end
        for (int j = 0; j < k; j++)
        begin
            outs[j].last = (j == k - 1);
            expected_sends.push_back(outs[j]);
        end
    endfunction

    function automatic sum_t pick_sum();
        int r;
        r = $urandom_range(3);
        if (r == 0)
            return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        if (r == 1)
            return $urandom;
        return sum_t'(int'($urandom_range(2000)) - 1000);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (err_count < PRINT_CAP)
            $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        err_count++;
    endtask

    task automatic send_msg(mode_t mode, idx_t sender, sum_t esum);
        @(negedge clk);
        if (!no_gaps)
        begin
            while ($urandom_range(99) < 13)
            begin
                s_tvalid = 1'b0;
                @(negedge clk);
            end
        end
        s_tdata  = {3'b000, esum, sender, mode};
        s_tvalid = 1'b1;
        @(posedge clk);
        while (s_tready !== 1'b1)
            @(posedge clk);
        predict_replies(mode, sender, esum);
        sent_items++;
    endtask

    // wait until every expected beat is out and the node has gone quiet
    task automatic settle_node();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (expected_sends.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [30:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == CFG_NEIGHBOURS)
        begin
            nb_count_reg = data[3:0];
        end
        else
        begin
            storage_reg = data;
            if (!seen_info && msg_count == '0)
                wave_sum = {1'b0, data};
        end
    endtask

    task automatic test_single_neighbour();
        send_msg(MODE_START, 3'd0, 32'd0);
        send_msg(MODE_INFO, 3'd0, 32'd0);
        send_msg(MODE_UNK, 3'd7, 32'hFFFF_FFFF);
        send_msg(MODE_INFO, 3'd3, 32'd0);
        send_msg(MODE_ECHO, 3'd0, -32'sd5);
    endtask

    task automatic test_saturation();
        settle_node();
        no_gaps = 1'b1;
        write_reg(CFG_NEIGHBOURS, 31'd15);
        write_reg(CFG_STORAGE, 31'h7FFF_FFFF);
        send_msg(MODE_INFO, 3'd7, 32'd0);
        send_msg(MODE_ECHO, 3'd0, 32'h7FFF_FFFF);
        send_msg(MODE_ECHO, 3'd1, 32'h8000_0000);
        send_msg(MODE_ECHO, 3'd2, 32'h8000_0000);
        send_msg(MODE_ECHO, 3'd3, 32'h8000_0000);
        // start while already informed floods again
        send_msg(MODE_START, 3'd5, 32'd0);
        send_msg(MODE_ECHO, 3'd4, 32'd1);
        send_msg(MODE_INFO, 3'd5, 32'd0);
        send_msg(MODE_ECHO, 3'd6, 32'hFFFF_FFFF);
        no_gaps = 1'b0;
    endtask

    task automatic test_storage_and_range();
        settle_node();
        write_reg(CFG_NEIGHBOURS, 31'd4);
        write_reg(CFG_STORAGE, 31'd100);
        send_msg(MODE_START, 3'd0, 32'd0);
        send_msg(MODE_INFO, 3'd0, 32'd0);
        send_msg(MODE_INFO, 3'd1, 32'd0);
        // mid-wave storage write must not touch the running sum
        settle_node();
        write_reg(CFG_STORAGE, 31'd5);
        send_msg(MODE_INFO, 3'd2, 32'd0);
        send_msg(MODE_ECHO, 3'd3, 32'd7);
        settle_node();
        write_reg(CFG_NEIGHBOURS, 31'd0);
        send_msg(MODE_INFO, 3'd0, 32'd0);
        send_msg(MODE_INFO, 3'd1, 32'd0);
    endtask

    // shrink the neighbour count below the count so far, forcing a wrap
    task automatic test_count_wrap();
        settle_node();
        write_reg(CFG_NEIGHBOURS, 31'd8);
        write_reg(CFG_STORAGE, 31'd0);
        send_msg(MODE_INFO, 3'd0, 32'd0);
        send_msg(MODE_INFO, 3'd1, 32'd0);
        send_msg(MODE_INFO, 3'd2, 32'd0);
        settle_node();
        write_reg(CFG_NEIGHBOURS, 31'd2);
        repeat (15)
            send_msg($urandom_range(1) ? MODE_ECHO : MODE_INFO,
                     idx_t'($urandom_range(1)), pick_sum());
    endtask

    task automatic test_backpressure();
        settle_node();
        write_reg(CFG_NEIGHBOURS, 31'd8);
        hold_req = 1'b1;
        repeat (6)
            send_msg(MODE_START, idx_t'($urandom_range(7)), $urandom);
        settle_node();
    endtask

    task automatic test_random_waves();
        int   goal;
        int   waves;
        int   n;
        int   r;
        logic [3:0]  nb;
        logic [30:0] store;
        goal  = sent_items + 50;
        waves = 0;
        while (sent_items < goal)
        begin
            no_gaps = (waves < 3);
            settle_node();
            r = $urandom_range(9);
            if (r == 0)
                nb = 4'd0;
            else if (r == 1)
                nb = 4'($urandom_range(15, 9));
            else
                nb = 4'($urandom_range(8, 1));
            r = $urandom_range(5);
            if (r == 0)
                store = '0;
            else if (r == 1)
                store = 31'h7FFF_FFFF;
            else if (r == 2)
                store = 31'($urandom);
            else
                store = 31'($urandom_range(5000));
            write_reg(CFG_NEIGHBOURS, {27'd0, nb});
            write_reg(CFG_STORAGE, store);
            n = eff_neighbours();
            if ($urandom_range(1))
                send_msg(MODE_START, idx_t'($urandom_range(7)), $urandom);
            repeat (n)
            begin
                if ($urandom_range(9) == 0)
                    send_msg(mode_t'($urandom_range(3)), idx_t'($urandom_range(7)),
                             $urandom);
                else
                    send_msg($urandom_range(1) ? MODE_ECHO : MODE_INFO,
                             idx_t'($urandom_range(n - 1)), pick_sum());
            end
            waves++;
        end
        no_gaps = 1'b0;
    endtask

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            m_tready = no_gaps || ($urandom_range(99) >= 13);
        end
    end

    always @(posedge clk)
    begin : check_beat
        sent_t want;
        if (rst_n && m_tvalid === 1'b1 && m_tready)
        begin
            if (expected_sends.size() == 0)
            begin
                report_mismatch("beat with nothing pending", m_tdata[31:0], '0);
            end
            else
            begin
                want = expected_sends.pop_front();
                if (m_tdata[1:0] !== want.kind)
                    report_mismatch("msg_kind", m_tdata[1:0], want.kind);
                if (m_tdata[4:2] !== want.dest)
                    report_mismatch("dest_index", m_tdata[4:2], want.dest);
                if (m_tdata[36:5] !== want.value)
                    report_mismatch("value", m_tdata[36:5], want.value);
                if (m_tlast !== want.last)
                    report_mismatch("last", m_tlast, want.last);
            end
        end
    end

    // count cycles with no beat on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("echo_wave_sum_node test failed");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_NEIGHBOURS;
        cfg_data     = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        no_gaps      = 1'b0;
        hold_req     = 1'b0;
        err_count    = 0;
        sent_items   = 0;
        stall_cycles = 0;
        nb_count_reg = 4'd1;
        storage_reg  = '0;
        parent_nb    = '0;
        node_to_idle();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_single_neighbour();
        test_saturation();
        test_storage_and_range();
        test_count_wrap();
        test_backpressure();
        test_random_waves();
        settle_node();

        if (err_count == 0)
            $display("echo_wave_sum_node test passed");
        else
            $display("echo_wave_sum_node test failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/ewsn_pkg.sv
rtl/core/ewsn_ctrl.sv
rtl/core/ewsn_dp.sv
rtl/core/echo_wave_sum_node.sv
test/tb.sv
